@@ hw/rtl/cbq_pkg.sv @@
// Shared types, constants and saturation helpers for the cascaded biquad equalizer.
// No dependencies; used by cbq_mulq, cbq_cell and cascaded_biquad_equalizer_core.
`default_nettype none

package cbq_pkg;

  localparam int BANDS      = 4;
  localparam int CHANNELS   = 2;
  localparam int NSTAGES    = BANDS + 2;
  localparam int NCOEF      = 5;
  localparam int STAGE_EN_W = 6;

  localparam int SAMPLE_W = 24;   // Q1.23
  localparam int COEF_W   = 32;   // Q7.25
  localparam int HIST_W   = 40;   // Q17.23
  localparam int ZLO_W    = 20;   // low half of a history word in the split product
  localparam int FRAC_W   = 25;
  localparam int PROD_W   = COEF_W + HIST_W - FRAC_W;   // scaled product
  localparam int ACC_W    = 50;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_COEF   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic {
    CFG_STAGE_ENABLE = 1'b0,
    CFG_CHANNELS     = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A1,
    ST_A2,
    ST_B1,
    ST_B2,
    ST_B0,
    ST_SUM,
    ST_OUT
  } cell_state_t;

  // sample token handed from cell to cell
  typedef struct packed {
    logic                     valid;
    logic                     active;
    logic                     ch;
    logic signed [HIST_W-1:0] x;
  } tok_t;

  typedef struct packed {
    logic                     we;
    coef_sel_t                sel;
    logic signed [COEF_W-1:0] value;
  } coef_wr_t;

  function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [ACC_W-1:0] a);
    logic signed [HIST_W-1:0] r;
    if ((&a[ACC_W-1:HIST_W-1]) || !(|a[ACC_W-1:HIST_W-1])) begin
      r = a[HIST_W-1:0];
    end else if (a[ACC_W-1]) begin
      r = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(HIST_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [HIST_W-1:0] a
  );
    logic signed [SAMPLE_W-1:0] r;
    if ((&a[HIST_W-1:SAMPLE_W-1]) || !(|a[HIST_W-1:SAMPLE_W-1])) begin
      r = a[SAMPLE_W-1:0];
    end else if (a[HIST_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cascaded_biquad_equalizer_core.sv @@
// Top level of the cascaded biquad equalizer: stream ports, config registers,
// the chain of cbq_cell stages and the result register. Depends on cbq_pkg, cbq_cell.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tuser: req, channel; s_tdata: sample, coef write
//  m_*       out  m_tvalid / m_tready    m_tdata: filtered sample; m_tuser: channel
//  cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The chain has six stages; each running stage issues five 32x40 products through
// its one split multiplier, and a bypassed stage passes the sample on. Coefficient
// writes and clears finish in the cycle they are accepted. s_tready stays low from
// acceptance of a sample until its result reaches the output register; a stalled
// result waits in a hold register so the output register can turn over. Reset is
// synchronous, clears coefficients and history, and sets config to all stages off, two channels.
`default_nettype none

module cascaded_biquad_equalizer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [23:0] sample_in, [26:24] stage_index, [29:27] coef_index, [61:30] coef_value
  input  wire logic [63:0] s_tdata,
  // [1:0] req_type, [2] channel
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [23:0] sample_out
  output logic [23:0]      m_tdata,
  // [0] out_channel
  output logic [0:0]       m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam int NST = cbq_pkg::NSTAGES;

  logic [1:0]                           req;
  logic                                 ch_in;
  logic signed [cbq_pkg::SAMPLE_W-1:0]  sample_in;
  logic [2:0]                           stage_index;
  logic [2:0]                           coef_index;
  logic signed [cbq_pkg::COEF_W-1:0]    coef_value;

  logic s_acc, is_sample, is_coef, is_clear, coef_ok, chan_ok, slot_free;

  logic [cbq_pkg::STAGE_EN_W-1:0] stage_en;
  logic [1:0]                     chans;
  logic                           busy, hold_valid;
  logic signed [cbq_pkg::SAMPLE_W-1:0] hold_sample, res_sample;
  logic                                hold_ch;

  cbq_pkg::tok_t     tok [NST+1];
  cbq_pkg::coef_wr_t wr  [NST];
  logic [NST-1:0]    en;
  logic [NST:0]      tok_v;

  assign req         = s_tuser[1:0];
  assign ch_in       = s_tuser[2];
  assign sample_in   = s_tdata[23:0];
  assign stage_index = s_tdata[26:24];
  assign coef_index  = s_tdata[29:27];
  assign coef_value  = s_tdata[61:30];

  assign s_tready  = !busy;
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign is_sample = s_acc && (req == cbq_pkg::REQ_SAMPLE);
  assign is_coef   = s_acc && (req == cbq_pkg::REQ_COEF);
  assign is_clear  = s_acc && (req == cbq_pkg::REQ_CLEAR);
  assign coef_ok   = 32'(coef_index) < cbq_pkg::NCOEF;
  assign chan_ok   = ({1'b0, ch_in} < chans) && (32'(ch_in) < cbq_pkg::CHANNELS);
  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    tok[0] = '{valid: is_sample, active: chan_ok, ch: ch_in,
               x: cbq_pkg::HIST_W'(sample_in)};
  end

  for (genvar s = 0; s < NST; s++) begin : g_cell
    if (s < cbq_pkg::STAGE_EN_W) begin : g_en
      assign en[s] = stage_en[s];
    end else begin : g_off
      assign en[s] = 1'b0;
    end

    assign wr[s] = '{we: is_coef && coef_ok && (32'(stage_index) == s),
                     sel: cbq_pkg::coef_sel_t'(coef_index), value: coef_value};

    cbq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en[s]),
      .tok_in  (tok[s]),
      .wr      (wr[s]),
      .clr     (is_clear),
      .tok_out (tok[s+1])
    );
  end

  always_comb begin
    for (int i = 0; i <= NST; i++) tok_v[i] = tok[i].valid;
  end

  assign res_sample = cbq_pkg::sat_sample(tok[NST].x);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_en   <= '0;
      chans      <= 2'd2;
      busy       <= 1'b0;
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cbq_pkg::cfg_reg_t'(cfg_index))
          cbq_pkg::CFG_STAGE_ENABLE: stage_en <= cfg_data;
          cbq_pkg::CFG_CHANNELS:     chans    <= cfg_data[1:0];
        endcase
      end
      if (is_sample) busy <= 1'b1;
      if (tok[NST].valid) begin
        if (slot_free) begin
          m_tvalid <= 1'b1;
          busy     <= 1'b0;
        end else begin
          hold_valid <= 1'b1;
        end
      end else if (hold_valid && slot_free) begin
        m_tvalid   <= 1'b1;
        hold_valid <= 1'b0;
        busy       <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[NST].valid) begin
      if (slot_free) begin
        m_tdata    <= res_sample;
        m_tuser[0] <= tok[NST].ch;
      end else begin
        hold_sample <= res_sample;
        hold_ch     <= tok[NST].ch;
      end
    end else if (hold_valid && slot_free) begin
      m_tdata    <= hold_sample;
      m_tuser[0] <= hold_ch;
    end
  end

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_v))
    else $error("more than one sample token in the chain");
  a_hold_busy: assert property (@(posedge clk) disable iff (rst) hold_valid |-> busy)
    else $error("held result without busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) is_sample |=> busy)
    else $error("accepted sample did not mark busy");
  a_end_free: assert property (@(posedge clk) disable iff (rst)
      tok[NST].valid |-> (busy && !hold_valid))
    else $error("chain result with no sample outstanding");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/cbq_mulq.sv @@
// Two-stage coefficient by history product, floor(c * z / 2^25).
// Uses cbq_pkg widths. The 40-bit history word is split into two halves.
`default_nettype none

module cbq_mulq (
  input  wire logic                                  clk,
  input  wire logic signed [cbq_pkg::COEF_W-1:0]     c,
  input  wire logic signed [cbq_pkg::HIST_W-1:0]     z,
  output logic signed [cbq_pkg::PROD_W-1:0]          p
);

  localparam int HI_W   = cbq_pkg::HIST_W - cbq_pkg::ZLO_W;
  localparam int MH_W   = cbq_pkg::COEF_W + HI_W;
  localparam int ML_W   = cbq_pkg::COEF_W + cbq_pkg::ZLO_W + 1;
  localparam int FULL_W = cbq_pkg::COEF_W + cbq_pkg::HIST_W;

  logic signed [HI_W-1:0]             zh;
  logic signed [cbq_pkg::ZLO_W:0]     zl;
  logic signed [MH_W-1:0]             mh;
  logic signed [ML_W-1:0]             ml;
  logic signed [FULL_W-1:0]           full;

  assign zh = z[cbq_pkg::HIST_W-1:cbq_pkg::ZLO_W];
  assign zl = $signed({1'b0, z[cbq_pkg::ZLO_W-1:0]});

  always_ff @(posedge clk) begin
    mh <= c * zh;
    ml <= c * zl;
  end

  // recombine the partial products; dropping the low bits is a floor shift
  assign full = $signed({mh, {cbq_pkg::ZLO_W{1'b0}}}) + FULL_W'(ml);

  always_ff @(posedge clk) begin
    p <= full[FULL_W-1:cbq_pkg::FRAC_W];
  end

endmodule

`default_nettype wire

@@ hw/rtl/cbq_cell.sv @@
// One biquad stage of the chain: coefficients, per-channel history and a sequencer
// around one split multiplier. Depends on cbq_pkg and cbq_mulq.
`default_nettype none

module cbq_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire cbq_pkg::tok_t     tok_in,
  input  wire cbq_pkg::coef_wr_t wr,
  input  wire logic              clr,
  output cbq_pkg::tok_t          tok_out
);

  cbq_pkg::cell_state_t state, state_next;

  logic signed [cbq_pkg::COEF_W-1:0] coef [cbq_pkg::NCOEF];
  logic signed [cbq_pkg::HIST_W-1:0] z1 [cbq_pkg::CHANNELS];
  logic signed [cbq_pkg::HIST_W-1:0] z2 [cbq_pkg::CHANNELS];

  logic signed [cbq_pkg::HIST_W-1:0] x_r, z1w, z2w, v, y;
  logic                              ch_r;
  logic signed [cbq_pkg::ACC_W-1:0]  vacc, yacc;
  logic signed [cbq_pkg::PROD_W-1:0] p;
  logic signed [cbq_pkg::COEF_W-1:0] c_op;
  logic signed [cbq_pkg::HIST_W-1:0] z_op;

  logic start, pass;
  logic ld_vacc, ld_v, ld_y0, add_y, fin;

  logic                              ov, oa, oc;
  logic signed [cbq_pkg::HIST_W-1:0] ox;

  assign start = (state == cbq_pkg::ST_IDLE) && tok_in.valid;
  assign pass  = start && !(en && tok_in.active);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cbq_pkg::ST_IDLE: if (start && !pass) state_next = cbq_pkg::ST_A1;
      cbq_pkg::ST_A1:   state_next = cbq_pkg::ST_A2;
      cbq_pkg::ST_A2:   state_next = cbq_pkg::ST_B1;
      cbq_pkg::ST_B1:   state_next = cbq_pkg::ST_B2;
      cbq_pkg::ST_B2:   state_next = cbq_pkg::ST_B0;
      cbq_pkg::ST_B0:   state_next = cbq_pkg::ST_SUM;
      cbq_pkg::ST_SUM:  state_next = cbq_pkg::ST_OUT;
      cbq_pkg::ST_OUT:  state_next = cbq_pkg::ST_IDLE;
      default:          state_next = cbq_pkg::ST_IDLE;
    endcase
  end

  // products reach p through both cbq_mulq registers, so accumulation trails issue
  always_comb begin
    c_op    = coef[cbq_pkg::COEF_A1];
    z_op    = z1w;
    ld_vacc = 1'b0;
    ld_v    = 1'b0;
    ld_y0   = 1'b0;
    add_y   = 1'b0;
    fin     = 1'b0;
    unique case (state)
      cbq_pkg::ST_IDLE: ;
      cbq_pkg::ST_A1: begin
        c_op = coef[cbq_pkg::COEF_A1];
        z_op = z1w;
      end
      cbq_pkg::ST_A2: begin
        c_op = coef[cbq_pkg::COEF_A2];
        z_op = z2w;
      end
      cbq_pkg::ST_B1: begin
        c_op    = coef[cbq_pkg::COEF_B1];
        z_op    = z1w;
        ld_vacc = 1'b1;
      end
      cbq_pkg::ST_B2: begin
        c_op = coef[cbq_pkg::COEF_B2];
        z_op = z2w;
        ld_v = 1'b1;
      end
      cbq_pkg::ST_B0: begin
        c_op  = coef[cbq_pkg::COEF_B0];
        z_op  = v;
        ld_y0 = 1'b1;
      end
      cbq_pkg::ST_SUM: add_y = 1'b1;
      cbq_pkg::ST_OUT: fin = 1'b1;
      default: ;
    endcase
  end

  cbq_mulq u_mul (
    .clk (clk),
    .c   (c_op),
    .z   (z_op),
    .p   (p)
  );

  assign y = cbq_pkg::sat_hist(yacc + cbq_pkg::ACC_W'(p));

  always_ff @(posedge clk) begin
    if (start) begin
      x_r  <= tok_in.x;
      ch_r <= tok_in.ch;
      z1w  <= z1[tok_in.ch];
      z2w  <= z2[tok_in.ch];
    end
    if (ld_vacc) vacc <= cbq_pkg::ACC_W'(x_r) - cbq_pkg::ACC_W'(p);
    if (ld_v)    v    <= cbq_pkg::sat_hist(vacc - cbq_pkg::ACC_W'(p));
    if (ld_y0) begin
      yacc <= cbq_pkg::ACC_W'(p);
    end else if (add_y) begin
      yacc <= yacc + cbq_pkg::ACC_W'(p);
    end
    if (pass) begin
      ox <= tok_in.x;
      oa <= tok_in.active;
      oc <= tok_in.ch;
    end else if (fin) begin
      ox <= y;
      oa <= 1'b1;
      oc <= ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else begin
      ov <= pass || fin;
    end
  end

  assign tok_out = '{valid: ov, active: oa, ch: oc, x: ox};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbq_pkg::NCOEF; i++) coef[i] <= '0;
    end else if (wr.we) begin
      coef[wr.sel] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < cbq_pkg::CHANNELS; i++) begin
        z1[i] <= '0;
        z2[i] <= '0;
      end
    end else if (fin) begin
      z1[ch_r] <= v;
      z2[ch_r] <= z1w;
    end
  end

endmodule

`default_nettype wire
